// ===== src/assert_macros.svh =====
// Concurrent assertion macros for the deque RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DQ_ASSERT(label, clk, rst_n, prop, msg)
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// No dependencies.
`timescale 1ns / 1ps
package dq_pkg;

    localparam int DQ_DEPTH    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int WORD_W      = 32;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_REAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [WORD_W-1:0] value;
    } t_dq_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic [1:0]               status;
    } t_dq_out;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [1:0]        status;
        logic [WORD_W-1:0] value;
    } t_dq_op;

    localparam int OP_W = $bits(t_dq_op);

endpackage

// ===== src/double_ended_queue.sv =====
// Double-ended queue of signed words: front classifier, short queue, executor.
// A command's operation is held in the short queue; its result is then registered in the executor.
// Throughput: one command per cycle while the output is not held off; the executor's single slot-memory port sets it.
// Reset clears head, occupancy and all handshake state; slot storage is not cleared.
// Depends on dq_pkg, dq_front, dq_fifo, dq_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module double_ended_queue import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dq_in  i_in_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dq_out o_out_item
);
    localparam int AW = $clog2(DEPTH);
    localparam int QW = AW + OP_W;

    logic          w_f_valid, w_f_ready;
    logic [AW-1:0] w_f_addr;
    t_dq_op        w_f_op;
    logic          w_q_valid, w_q_ready;
    logic [QW-1:0] w_q_data;
    logic [AW-1:0] w_q_addr;
    t_dq_op        w_q_op;
    logic          w_in_take;

    assign w_in_take = i_in_valid && o_in_ready;

    dq_front #(.DEPTH(DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_addr  (w_f_addr),
        .o_op    (w_f_op)
    );

    dq_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  ({w_f_addr, w_f_op}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    assign w_q_addr = w_q_data[QW-1 -: AW];
    assign w_q_op   = t_dq_op'(w_q_data[OP_W-1:0]);

    dq_back #(.DEPTH(DEPTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_addr  (w_q_addr),
        .i_op    (w_q_op),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    `DQ_ASSERT(a_refused_zero, i_clk, i_rst_n, !(o_out_valid && o_out_item.status != ST_OK) || o_out_item.popped == '0, "refused command returned a nonzero word")
    `DQ_ASSERT(a_read_only_ok, i_clk, i_rst_n, !(w_q_valid && w_q_op.rd_en) || w_q_op.status == ST_OK, "slot read queued for a refused pop")
    `DQ_ASSERT(a_no_rd_and_wr, i_clk, i_rst_n, !(w_q_valid && w_q_op.rd_en && w_q_op.wr_en), "queued operation both reads and writes")
    `DQ_ASSERT_NEXT(a_item_kept, i_clk, i_rst_n, w_in_take, w_q_valid || o_out_valid, "accepted item lost")

endmodule

// ===== src/dq_fifo.sv =====
// Short queue that decouples the classifier from the executor.
// Depends on dq_pkg for its depth.
`timescale 1ns / 1ps
module dq_fifo import dq_pkg::*; #(
    parameter int WIDTH = OP_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_buf [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count,  n_count;
    logic             w_push, w_pop;

    assign o_ready = r_count != QCW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_buf[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/dq_front.sv =====
// Front end: accepts commands, tracks head and occupancy, classifies each item.
// Depends on dq_pkg for command, status and operation types.
`timescale 1ns / 1ps
module dq_front import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_dq_in                    i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [$clog2(DEPTH)-1:0]  o_addr,
    output t_dq_op                    o_op
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_occ,  n_occ;
    logic          w_take, w_full, w_empty;
    logic [SW-1:0] w_rear_sum;
    logic [AW-1:0] w_rear_wr, w_rear_rd, w_head_inc, w_head_dec;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        return (s >= SW'(DEPTH)) ? AW'(s - SW'(DEPTH)) : AW'(s);
    endfunction

    assign o_valid    = i_valid;
    assign o_ready    = i_ready;
    assign w_take     = i_valid && i_ready;
    assign w_full     = r_occ == CW'(DEPTH);
    assign w_empty    = r_occ == '0;
    assign w_rear_sum = SW'(r_head) + SW'(r_occ);
    assign w_rear_wr  = wrap(w_rear_sum);
    assign w_rear_rd  = wrap(w_rear_sum - 1'b1);
    assign w_head_inc = wrap(SW'(r_head) + 1'b1);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;

    always_comb begin
        n_head      = r_head;
        n_occ       = r_occ;
        o_addr      = r_head;
        o_op.wr_en  = 1'b0;
        o_op.rd_en  = 1'b0;
        o_op.status = ST_OK;
        o_op.value  = i_item.value;
        case (i_item.command)
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_addr     = w_head_dec;
                    o_op.wr_en = 1'b1;
                    n_head     = w_head_dec;
                    n_occ      = r_occ + 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (w_full) begin
                    o_op.status = ST_FULL;
                end else begin
                    o_addr     = w_rear_wr;
                    o_op.wr_en = 1'b1;
                    n_occ      = r_occ + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_addr     = r_head;
                    o_op.rd_en = 1'b1;
                    n_head     = w_head_inc;
                    n_occ      = r_occ - 1'b1;
                end
            end
            default: begin
                if (w_empty) begin
                    o_op.status = ST_EMPTY;
                end else begin
                    o_addr     = w_rear_rd;
                    o_op.rd_en = 1'b1;
                    n_occ      = r_occ - 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else if (w_take) begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

endmodule

// ===== src/dq_back.sv =====
// Back end: carries out slot writes and reads, holds the result item.
// Depends on dq_pkg for operation and result types.
`timescale 1ns / 1ps
module dq_back import dq_pkg::*; #(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [$clog2(DEPTH)-1:0]  i_addr,
    input  t_dq_op                    i_op,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_dq_out                   o_item
);
    logic [WORD_W-1:0] r_slots [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_en;
    logic [1:0]        r_status;
    logic              r_out_valid;
    logic              w_take;

    assign o_ready       = !r_out_valid || i_ready;
    assign w_take        = i_valid && o_ready;
    assign o_valid       = r_out_valid;
    assign o_item.popped = r_rd_en ? r_rd_data : '0;
    assign o_item.status = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rd_en  <= i_op.rd_en;
            r_status <= i_op.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_op.wr_en) begin
            r_slots[i_addr] <= i_op.value;
        end
        if (w_take && i_op.rd_en) begin
            r_rd_data <= r_slots[i_addr];
        end
    end

endmodule

// ===== verif/tb_double_ended_queue.sv =====
// Self-checking testbench for double_ended_queue: directed and random deque commands.
// It predicts every result with its own deque model and checks each one in order.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_LEN     = 200;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        PH_FREE,
        PH_TX_IDLE,
        PH_RX_STALL,
        PH_BOTH,
        PH_PRESSURE
    } t_tb_phase;

    typedef struct {
        t_dq_in    item;
        t_tb_phase phase;
    } t_pending;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_dq_in    in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_dq_out   out_item;
    t_tb_phase cur_phase = PH_FREE;
    logic      rx_hold   = 1'b0;
    int        hold_cycles   = 0;
    int        cycle_count   = 0;
    int        mismatch_count = 0;

    t_pending pending_cmds [$];
    t_dq_out  expected_results [$];

    logic [WORD_W-1:0] model_slots [DQ_DEPTH];
    int                model_head  = 0;
    int                model_count = 0;

    double_ended_queue u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic t_dq_out deque_apply(input t_dq_in cmd);
        t_dq_out res;
        int      idx;
        res.popped = '0;
        res.status = ST_OK;
        case (cmd.command)
            CMD_PUSH_FRONT: begin
                if (model_count == DQ_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_head = (model_head + DQ_DEPTH - 1) % DQ_DEPTH;
                    model_slots[model_head] = cmd.value;
                    model_count++;
                end
            end
            CMD_PUSH_REAR: begin
                if (model_count == DQ_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx = (model_head + model_count) % DQ_DEPTH;
                    model_slots[idx] = cmd.value;
                    model_count++;
                end
            end
            CMD_POP_FRONT: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped = model_slots[model_head];
                    model_head = (model_head + 1) % DQ_DEPTH;
                    model_count--;
                end
            end
            default: begin
                if (model_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx = (model_head + model_count - 1) % DQ_DEPTH;
                    res.popped = model_slots[idx];
                    model_count--;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic queue_cmd(input logic [1:0] command, input logic [31:0] value,
                             input t_tb_phase phase);
        t_pending p;
        p.item.command = command;
        p.item.value   = value;
        p.phase        = phase;
        pending_cmds.push_back(p);
    endtask

    task automatic queue_random(input int count, input t_tb_phase phase);
        int          push_bias;
        int          sel;
        logic [1:0]  command;
        logic [31:0] value;
        push_bias = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                case ($urandom_range(4))
                    0: push_bias = 10;
                    1: push_bias = 25;
                    2: push_bias = 50;
                    3: push_bias = 75;
                    default: push_bias = 90;
                endcase
            end
            if ($urandom_range(99) < push_bias) begin
                command = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
            end else begin
                command = $urandom_range(1) ? CMD_POP_REAR : CMD_POP_FRONT;
            end
            sel = $urandom_range(9);
            case (sel)
                0: value = 32'h7FFF_FFFF;
                1: value = 32'h8000_0000;
                2: value = $urandom_range(15);
                default: value = $urandom;
            endcase
            queue_cmd(command, value, phase);
        end
    endtask

    // driver: offer the next pending item once the current one is taken
    always @(posedge clk) begin : drive_proc
        t_pending nxt;
        int       idle_pct;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(deque_apply(in_item));
            end
            if (!in_valid || in_ready) begin
                idle_pct = 0;
                if (pending_cmds.size() > 0) begin
                    idle_pct = (pending_cmds[0].phase == PH_TX_IDLE) ? 67 :
                               (pending_cmds[0].phase == PH_BOTH)    ? 35 : 0;
                end
                if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = pending_cmds.pop_front();
                    in_item   <= nxt.item;
                    cur_phase <= nxt.phase;
                    in_valid  <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // hold the receiver off for a long stretch while the pressure items arrive
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_hold     <= 1'b0;
            hold_cycles <= 0;
        end else if (cur_phase == PH_PRESSURE && hold_cycles < HOLD_LEN) begin
            rx_hold     <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            rx_hold <= 1'b0;
        end
    end

    always @(posedge clk) begin : monitor_proc
        t_dq_out want;
        int      stall_pct;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected item", out_item.popped, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.popped !== want.popped) begin
                        report_mismatch("popped", out_item.popped, want.popped);
                    end
                    if (out_item.status !== want.status) begin
                        report_mismatch("status", 32'(out_item.status), 32'(want.status));
                    end
                end
            end
            stall_pct = (cur_phase == PH_RX_STALL) ? 67 :
                        (cur_phase == PH_BOTH)     ? 35 : 0;
            out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        // empty pops, extremes, head wrap below zero, full pushes, drain
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'hFFFF_FFFF, PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'h8000_0000, PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'h0000_0000, PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'h5555_5555, PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'h7FFF_FFFF, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'h8000_0000, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'h0000_0001, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'hFFFF_FFFE, PH_FREE);
        queue_cmd(CMD_PUSH_FRONT, 32'hFFFF_FFFF, PH_FREE);
        queue_cmd(CMD_PUSH_REAR,  32'hFFFF_FFFF, PH_FREE);
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_POP_FRONT,  32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);
        queue_cmd(CMD_POP_REAR,   32'h0,         PH_FREE);

        queue_random(300, PH_FREE);
        queue_random(280, PH_TX_IDLE);
        queue_random(40,  PH_PRESSURE);
        queue_random(280, PH_RX_STALL);
        queue_random(250, PH_BOTH);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_valid) @(negedge clk);
        while (expected_results.size() > 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue.f =====
+incdir+src
src/dq_pkg.sv
src/dq_fifo.sv
src/dq_front.sv
src/dq_back.sv
src/double_ended_queue.sv
verif/tb_double_ended_queue.sv
